@@ hw/rtl/websocket_deframer_line_splitter_top_assert.svh @@
// assertion macros shared by the deframer modules
`ifndef WEBSOCKET_DEFRAMER_LINE_SPLITTER_TOP_ASSERT_SVH
`define WEBSOCKET_DEFRAMER_LINE_SPLITTER_TOP_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define WSLS_ASSERT_IMP(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("wsls assertion failed");

// next-cycle implication, disabled while in reset
`define WSLS_ASSERT_NXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("wsls assertion failed");

`endif

@@ hw/rtl/wsls_pkg.sv @@
// shared types and constants of the websocket deframer and line splitter
package wsls_pkg;

  // line assembler sizing
  localparam int unsigned LINE_MAX   = 64;
  localparam int unsigned LINE_DEPTH = LINE_MAX - 1;
  localparam int unsigned LINE_AW    = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
  localparam int unsigned FILL_W     = $clog2(LINE_MAX);

  // queue between parser and executor
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // configuration register
  localparam int unsigned CFG_W = 16;
  localparam logic [CFG_W-1:0] BUF_SIZE_RESET = 16'd2048;

  // frame opcodes
  localparam logic [3:0] OPC_TEXT  = 4'h1;
  localparam logic [3:0] OPC_CLOSE = 4'h8;
  localparam logic [3:0] OPC_PING  = 4'h9;

  // length byte codes
  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;

  // header byte counts
  localparam logic [3:0] HDR_BASE    = 4'd2;
  localparam logic [3:0] HDR_EXT16   = 4'd4;
  localparam logic [3:0] HDR_EXT64   = 4'd10;
  localparam logic [3:0] MASK_KEY    = 4'd4;
  localparam logic [3:0] EXT16_BYTES = 4'd2;
  localparam logic [3:0] EXT64_BYTES = 4'd8;

  // line end characters
  localparam logic [7:0] CHR_LF = 8'h0A;
  localparam logic [7:0] CHR_CR = 8'h0D;

  typedef logic [FILL_W-1:0]   fill_t;
  typedef logic [LINE_AW-1:0]  line_addr_t;
  typedef logic [QUEUE_AW-1:0] qptr_t;
  typedef logic [QCNT_W-1:0]   qcnt_t;

  typedef enum logic [2:0] {
    KIND_CHAR      = 3'd0,
    KIND_PING_BYTE = 3'd1,
    KIND_PING_DONE = 3'd2,
    KIND_CLOSE     = 3'd3,
    KIND_OVERFLOW  = 3'd4
  } res_kind_e;

  typedef enum logic {
    ACT_LINE = 1'b0,
    ACT_EMIT = 1'b1
  } op_act_e;

  // one queued operation for the executor
  typedef struct packed {
    op_act_e   act;
    res_kind_e kind;
    logic [7:0] data;
    logic      tail;
  } op_t;

  typedef enum logic [2:0] {
    PH_FIRST   = 3'd0,
    PH_SECOND  = 3'd1,
    PH_EXTLEN  = 3'd2,
    PH_MASK    = 3'd3,
    PH_PAYLOAD = 3'd4
  } parse_phase_e;

  // frame parser state; payload length kept as its low 16 bits plus a nonzero flag for the rest
  typedef struct packed {
    parse_phase_e phase;
    logic [3:0]   hdr_left;
    logic [3:0]   opcode;
    logic         mask;
    logic [3:0]   hdr_len;
    logic         pl_hi;
    logic [15:0]  pl_lo;
    logic [15:0]  pay_left;
  } parse_t;

  localparam parse_t PARSE_CLEAR = '{
    phase:    PH_FIRST,
    hdr_left: 4'd0,
    opcode:   4'd0,
    mask:     1'b0,
    hdr_len:  4'd0,
    pl_hi:    1'b0,
    pl_lo:    16'd0,
    pay_left: 16'd0
  };

  typedef enum logic [1:0] {
    BK_IDLE  = 2'd0,
    BK_TAIL  = 2'd1,
    BK_FLUSH = 2'd2
  } back_state_e;

endpackage

@@ hw/rtl/wsls_in_if.sv @@
// received byte channel
interface wsls_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] rx_byte;

  modport source (output valid, output cmd, output rx_byte, input ready);
  modport sink   (input valid, input cmd, input rx_byte, output ready);
endinterface

@@ hw/rtl/wsls_out_if.sv @@
// result channel
interface wsls_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] kind;
  logic [7:0] data;
  logic       last;

  modport source (output valid, output kind, output data, output last, input ready);
  modport sink   (input valid, input kind, input data, input last, output ready);
endinterface

@@ hw/rtl/wsls_ram.sv @@
// generic single-port-write ram with registered read
module wsls_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 63
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                          wdata_i,
  input  logic                                      re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read, held while not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/wsls_queue.sv @@
// short operation queue between frame parser and executor
`include "websocket_deframer_line_splitter_top_assert.svh"
module wsls_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  wsls_pkg::op_t  op_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output wsls_pkg::op_t  head_o
);

  wsls_pkg::op_t   slot_q [wsls_pkg::QUEUE_DEPTH];
  wsls_pkg::qptr_t wr_ptr_q, wr_ptr_d;
  wsls_pkg::qptr_t rd_ptr_q, rd_ptr_d;
  wsls_pkg::qcnt_t cnt_q, cnt_d;

  assign full_o  = (cnt_q == wsls_pkg::qcnt_t'(wsls_pkg::QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = slot_q[rd_ptr_q];

  // pointer and count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == wsls_pkg::qptr_t'(wsls_pkg::QUEUE_DEPTH - 1)) ? '0 :
                 wsls_pkg::qptr_t'(wr_ptr_q + wsls_pkg::qptr_t'(1));
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == wsls_pkg::qptr_t'(wsls_pkg::QUEUE_DEPTH - 1)) ? '0 :
                 wsls_pkg::qptr_t'(rd_ptr_q + wsls_pkg::qptr_t'(1));
    end
    if (push_i && !pop_i) begin
      cnt_d = wsls_pkg::qcnt_t'(cnt_q + wsls_pkg::qcnt_t'(1));
    end else if (pop_i && !push_i) begin
      cnt_d = wsls_pkg::qcnt_t'(cnt_q - wsls_pkg::qcnt_t'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // slot storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= op_i;
    end
  end

  `WSLS_ASSERT_IMP(a_no_pop_empty, clk_i, rst_ni, pop_i, !empty_o)
  `WSLS_ASSERT_IMP(a_no_push_full, clk_i, rst_ni, push_i, !full_o)

endmodule

@@ hw/rtl/wsls_front.sv @@
// frame header parser: classifies each received byte, queuing any operation
`include "websocket_deframer_line_splitter_top_assert.svh"
module wsls_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [wsls_pkg::CFG_W-1:0]  buf_size_i,
  wsls_in_if.sink                     rx,
  input  logic                        full_i,
  output logic                        push_o,
  output wsls_pkg::op_t               op_o
);

  wsls_pkg::parse_t st_q, st_d;
  logic             closed_q, closed_d;

  logic        acc, live;
  logic [7:0]  rx_byte;
  logic [6:0]  len7;
  logic        is_ext;
  logic        sh_hi;
  logic [15:0] sh_lo;
  logic        hd_fire;
  logic [3:0]  hd_hl;
  logic        hd_hi;
  logic [15:0] hd_lo;
  logic [16:0] hd_sum;
  logic        ovf;
  logic        pay_end;
  logic        fire_ovf, fire_fd, fire_pay;

  assign rx.ready = !full_i;
  assign acc      = rx.valid && rx.ready;
  assign live     = acc && !rx.cmd && !closed_q;
  assign rx_byte  = rx.rx_byte;
  assign len7     = rx_byte[6:0];
  assign is_ext   = (len7 == wsls_pkg::LEN_EXT16) || (len7 == wsls_pkg::LEN_EXT64);

  // extended length shifted by one byte
  assign sh_hi = st_q.pl_hi || (st_q.pl_lo[15:8] != 8'd0);
  assign sh_lo = {st_q.pl_lo[7:0], rx_byte};

  // header completion on this byte
  assign hd_fire = live && (
      (st_q.phase == wsls_pkg::PH_SECOND && !is_ext && !rx_byte[7]) ||
      (st_q.phase == wsls_pkg::PH_EXTLEN && st_q.hdr_left <= 4'd1 && !st_q.mask) ||
      (st_q.phase == wsls_pkg::PH_MASK && st_q.hdr_left <= 4'd1));

  // header length and payload length as seen at header completion
  always_comb begin
    hd_hl = st_q.hdr_len;
    hd_hi = st_q.pl_hi;
    hd_lo = st_q.pl_lo;
    if (st_q.phase == wsls_pkg::PH_SECOND) begin
      hd_hl = wsls_pkg::HDR_BASE;
      hd_hi = 1'b0;
      hd_lo = {9'd0, len7};
    end else if (st_q.phase == wsls_pkg::PH_EXTLEN) begin
      hd_hi = sh_hi;
      hd_lo = sh_lo;
    end
  end

  // buffer limit check
  assign hd_sum = {1'b0, hd_lo} + {13'd0, hd_hl};
  assign ovf    = hd_hi || (hd_sum > {1'b0, buf_size_i});

  assign pay_end  = live && (st_q.phase == wsls_pkg::PH_PAYLOAD) && (st_q.pay_left <= 16'd1);
  assign fire_ovf = hd_fire && ovf;
  assign fire_fd  = (hd_fire && !ovf && (hd_lo == 16'd0)) || pay_end;
  assign fire_pay = hd_fire && !ovf && (hd_lo != 16'd0);

  // next parser state
  always_comb begin
    st_d     = st_q;
    closed_d = closed_q;
    if (acc && rx.cmd) begin
      st_d     = wsls_pkg::PARSE_CLEAR;
      closed_d = 1'b0;
    end else if (live) begin
      unique case (st_q.phase)
        wsls_pkg::PH_FIRST: begin
          st_d.opcode  = rx_byte[3:0];
          st_d.hdr_len = wsls_pkg::HDR_BASE;
          st_d.phase   = wsls_pkg::PH_SECOND;
        end
        wsls_pkg::PH_SECOND: begin
          st_d.mask  = rx_byte[7];
          st_d.pl_hi = 1'b0;
          st_d.pl_lo = 16'd0;
          if (len7 == wsls_pkg::LEN_EXT16) begin
            st_d.hdr_left = wsls_pkg::EXT16_BYTES;
            st_d.hdr_len  = wsls_pkg::HDR_EXT16;
            st_d.phase    = wsls_pkg::PH_EXTLEN;
          end else if (len7 == wsls_pkg::LEN_EXT64) begin
            st_d.hdr_left = wsls_pkg::EXT64_BYTES;
            st_d.hdr_len  = wsls_pkg::HDR_EXT64;
            st_d.phase    = wsls_pkg::PH_EXTLEN;
          end else begin
            st_d.pl_lo = {9'd0, len7};
            if (rx_byte[7]) begin
              st_d.hdr_left = wsls_pkg::MASK_KEY;
              st_d.hdr_len  = wsls_pkg::HDR_BASE + wsls_pkg::MASK_KEY;
              st_d.phase    = wsls_pkg::PH_MASK;
            end
          end
        end
        wsls_pkg::PH_EXTLEN: begin
          st_d.pl_hi = sh_hi;
          st_d.pl_lo = sh_lo;
          if (st_q.hdr_left != 4'd0) begin
            st_d.hdr_left = st_q.hdr_left - 4'd1;
          end
          if (st_q.hdr_left <= 4'd1 && st_q.mask) begin
            st_d.hdr_left = wsls_pkg::MASK_KEY;
            st_d.hdr_len  = st_q.hdr_len + wsls_pkg::MASK_KEY;
            st_d.phase    = wsls_pkg::PH_MASK;
          end
        end
        wsls_pkg::PH_MASK: begin
          if (st_q.hdr_left != 4'd0) begin
            st_d.hdr_left = st_q.hdr_left - 4'd1;
          end
        end
        wsls_pkg::PH_PAYLOAD: begin
          if (st_q.pay_left != 16'd0) begin
            st_d.pay_left = st_q.pay_left - 16'd1;
          end
        end
        default: begin
          st_d = wsls_pkg::PARSE_CLEAR;
        end
      endcase
      // header and frame completion
      if (fire_ovf) begin
        st_d     = wsls_pkg::PARSE_CLEAR;
        closed_d = 1'b1;
      end else if (fire_fd) begin
        if (st_q.opcode == wsls_pkg::OPC_CLOSE) begin
          closed_d = 1'b1;
        end
        st_d = wsls_pkg::PARSE_CLEAR;
      end else if (fire_pay) begin
        st_d.pay_left = hd_lo;
        st_d.phase    = wsls_pkg::PH_PAYLOAD;
      end
    end
  end

  // operation issued to the queue
  always_comb begin
    push_o      = 1'b0;
    op_o.act    = wsls_pkg::ACT_EMIT;
    op_o.kind   = wsls_pkg::KIND_CHAR;
    op_o.data   = 8'd0;
    op_o.tail   = 1'b0;
    if (fire_ovf) begin
      push_o    = 1'b1;
      op_o.kind = wsls_pkg::KIND_OVERFLOW;
    end else if (live && st_q.phase == wsls_pkg::PH_PAYLOAD) begin
      if (st_q.opcode == wsls_pkg::OPC_TEXT) begin
        push_o   = 1'b1;
        op_o.act = wsls_pkg::ACT_LINE;
        op_o.data = rx_byte;
      end else if (st_q.opcode == wsls_pkg::OPC_PING) begin
        push_o    = 1'b1;
        op_o.kind = wsls_pkg::KIND_PING_BYTE;
        op_o.data = rx_byte;
        op_o.tail = pay_end;
      end else if (st_q.opcode == wsls_pkg::OPC_CLOSE && pay_end) begin
        push_o    = 1'b1;
        op_o.kind = wsls_pkg::KIND_CLOSE;
      end
    end else if (fire_fd) begin
      if (st_q.opcode == wsls_pkg::OPC_PING) begin
        push_o    = 1'b1;
        op_o.kind = wsls_pkg::KIND_PING_DONE;
      end else if (st_q.opcode == wsls_pkg::OPC_CLOSE) begin
        push_o    = 1'b1;
        op_o.kind = wsls_pkg::KIND_CLOSE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= wsls_pkg::PARSE_CLEAR;
      closed_q <= 1'b0;
    end else begin
      st_q     <= st_d;
      closed_q <= closed_d;
    end
  end

  `WSLS_ASSERT_IMP(a_closed_parser_idle, clk_i, rst_ni, closed_q, st_q.phase == wsls_pkg::PH_FIRST)

endmodule

@@ hw/rtl/wsls_back.sv @@
// executor: line assembler, ping echo and event output with a result register
`include "websocket_deframer_line_splitter_top_assert.svh"
module wsls_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           empty_i,
  input  wsls_pkg::op_t  head_i,
  output logic           pop_o,
  wsls_out_if.source     res
);

  wsls_pkg::back_state_e state_q, state_d;
  wsls_pkg::fill_t       fill_q, fill_d;
  wsls_pkg::line_addr_t  rd_addr_q, rd_addr_d;
  logic                  rlast_q, rlast_d;
  logic                  out_valid_q, out_valid_d;
  wsls_pkg::res_kind_e   out_kind_q, out_kind_d;
  logic [7:0]            out_data_q, out_data_d;
  logic                  out_last_q, out_last_d;

  logic                  load_ok, load;
  logic                  is_eol;
  logic                  ram_we, ram_re;
  wsls_pkg::line_addr_t  ram_raddr;
  logic [7:0]            ram_rdata;

  assign load_ok = !out_valid_q || res.ready;
  assign is_eol  = (head_i.data == wsls_pkg::CHR_LF) || (head_i.data == wsls_pkg::CHR_CR);
  assign pop_o   = (state_q == wsls_pkg::BK_IDLE) && !empty_i &&
                   ((head_i.act == wsls_pkg::ACT_LINE) || load_ok);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      wsls_pkg::BK_IDLE: begin
        if (pop_o) begin
          if (head_i.act == wsls_pkg::ACT_EMIT) begin
            if (head_i.tail) begin
              state_d = wsls_pkg::BK_TAIL;
            end
          end else if (is_eol && fill_q != '0) begin
            state_d = wsls_pkg::BK_FLUSH;
          end
        end
      end
      wsls_pkg::BK_TAIL: begin
        if (load_ok) begin
          state_d = wsls_pkg::BK_IDLE;
        end
      end
      wsls_pkg::BK_FLUSH: begin
        if (load_ok && rlast_q) begin
          state_d = wsls_pkg::BK_IDLE;
        end
      end
      default: begin
        state_d = wsls_pkg::BK_IDLE;
      end
    endcase
  end

  // datapath and result loading
  always_comb begin
    fill_d     = fill_q;
    rd_addr_d  = rd_addr_q;
    rlast_d    = rlast_q;
    load       = 1'b0;
    out_kind_d = out_kind_q;
    out_data_d = out_data_q;
    out_last_d = out_last_q;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    ram_raddr  = rd_addr_q;
    unique case (state_q)
      wsls_pkg::BK_IDLE: begin
        if (pop_o) begin
          if (head_i.act == wsls_pkg::ACT_EMIT) begin
            load       = 1'b1;
            out_kind_d = head_i.kind;
            out_data_d = head_i.data;
            out_last_d = !head_i.tail;
          end else if (is_eol) begin
            // start reading the line out from the first char
            if (fill_q != '0) begin
              ram_re    = 1'b1;
              ram_raddr = '0;
              rd_addr_d = wsls_pkg::line_addr_t'(1);
              rlast_d   = (fill_q == wsls_pkg::fill_t'(1));
            end
          end else if (fill_q < wsls_pkg::fill_t'(wsls_pkg::LINE_DEPTH)) begin
            ram_we = 1'b1;
            fill_d = wsls_pkg::fill_t'(fill_q + wsls_pkg::fill_t'(1));
          end else begin
            // line too long: drop it and this char
            fill_d = '0;
          end
        end
      end
      wsls_pkg::BK_TAIL: begin
        if (load_ok) begin
          load       = 1'b1;
          out_kind_d = wsls_pkg::KIND_PING_DONE;
          out_data_d = 8'd0;
          out_last_d = 1'b1;
        end
      end
      wsls_pkg::BK_FLUSH: begin
        if (load_ok) begin
          load       = 1'b1;
          out_kind_d = wsls_pkg::KIND_CHAR;
          out_data_d = ram_rdata;
          out_last_d = rlast_q;
          if (rlast_q) begin
            fill_d = '0;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = rd_addr_q;
            rd_addr_d = wsls_pkg::line_addr_t'(rd_addr_q + wsls_pkg::line_addr_t'(1));
            rlast_d   = (wsls_pkg::fill_t'(rd_addr_q) ==
                         wsls_pkg::fill_t'(fill_q - wsls_pkg::fill_t'(1)));
          end
        end
      end
      default: begin
        fill_d = fill_q;
      end
    endcase
  end

  // result valid tracking
  always_comb begin
    if (load) begin
      out_valid_d = 1'b1;
    end else if (res.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= wsls_pkg::BK_IDLE;
      fill_q      <= '0;
      rd_addr_q   <= '0;
      rlast_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      rd_addr_q   <= rd_addr_d;
      rlast_q     <= rlast_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result payload register
  always_ff @(posedge clk_i) begin
    out_kind_q <= out_kind_d;
    out_data_q <= out_data_d;
    out_last_q <= out_last_d;
  end

  // line store
  wsls_ram #(
    .WIDTH (8),
    .DEPTH (wsls_pkg::LINE_DEPTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wsls_pkg::line_addr_t'(fill_q)),
    .wdata_i (head_i.data),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign res.valid = out_valid_q;
  assign res.kind  = out_kind_q;
  assign res.data  = out_data_q;
  assign res.last  = out_last_q;

  `WSLS_ASSERT_IMP(a_tail_holds_result, clk_i, rst_ni, state_q == wsls_pkg::BK_TAIL, out_valid_q)
  `WSLS_ASSERT_IMP(a_flush_nonempty, clk_i, rst_ni, state_q == wsls_pkg::BK_FLUSH, fill_q != '0)

endmodule

@@ hw/rtl/websocket_deframer_line_splitter_top.sv @@
// top level of the websocket deframer and text line splitter
// Takes one received byte (or a session start) per cycle while the four-entry operation queue has
// room; the frame parser classifies each byte in that cycle. Results leave through a registered
// output at up to one per cycle: a ping byte is followed by its completion event; a line end
// starts the line store read, then outputs each stored char, all paced by the single read port
// of the 63-entry line store. While a line is read out the queue absorbs up to four further bytes
// before input stalls. The buffer size register is written through cfg_we_i and cfg_wdata_i and
// resets to 2048; the user must write it only while the block is idle, which is not enforced.
module websocket_deframer_line_splitter_top (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [wsls_pkg::CFG_W-1:0] cfg_wdata_i,
  wsls_in_if.sink                    rx_i,
  wsls_out_if.source                 res_o
);

  logic [wsls_pkg::CFG_W-1:0] buf_size_q, buf_size_d;
  logic                       push, pop, full, empty;
  wsls_pkg::op_t              push_op, head_op;

  // buffer size register
  assign buf_size_d = cfg_we_i ? cfg_wdata_i : buf_size_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_size_q <= wsls_pkg::BUF_SIZE_RESET;
    end else begin
      buf_size_q <= buf_size_d;
    end
  end

  // frame parser
  wsls_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .buf_size_i (buf_size_q),
    .rx         (rx_i),
    .full_i     (full),
    .push_o     (push),
    .op_o       (push_op)
  );

  // operation queue
  wsls_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .op_i    (push_op),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .head_o  (head_op)
  );

  // executor
  wsls_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (empty),
    .head_i  (head_op),
    .pop_o   (pop),
    .res     (res_o)
  );

endmodule

@@ tb/sv/websocket_deframer_line_splitter_checker.sv @@
// scoreboard of the websocket deframer: predicts the results of each accepted word and checks them
module websocket_deframer_line_splitter_checker
  import wsls_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  wsls_in_if               rx_i,
  wsls_out_if              res_i,
  output int unsigned      errors_o,
  output int unsigned      pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // one word can cause at most this many results
  localparam int unsigned MAX_CAUSED = 63;

  typedef struct packed {
    res_kind_e  kind;
    logic [7:0] data;
    logic       last;
  } result_t;

  // predicted block state
  logic [CFG_W-1:0] buf_size;
  parse_phase_e     phase;
  logic [3:0]       hdr_left;
  logic [3:0]       opcode;
  logic [3:0]       hdr_len;
  logic             mask_bit;
  logic [63:0]      frame_len;
  logic [15:0]      bytes_left;
  logic             closed;
  logic [7:0]       line_mem [LINE_DEPTH];
  int unsigned      line_fill;

  result_t expected_q[$];
  result_t caused_q[$];

  function automatic void add_result(res_kind_e k, logic [7:0] d);
    if (caused_q.size() < MAX_CAUSED) caused_q.push_back('{kind: k, data: d, last: 1'b0});
  endfunction

  function automatic void clear_parser();
    phase      = PH_FIRST;
    hdr_left   = '0;
    opcode     = '0;
    hdr_len    = '0;
    mask_bit   = 1'b0;
    frame_len  = '0;
    bytes_left = '0;
  endfunction

  // last byte of a frame: ping and close raise their events here
  function automatic void frame_end();
    if (opcode == OPC_PING) begin
      add_result(KIND_PING_DONE, 8'h00);
    end else if (opcode == OPC_CLOSE) begin
      add_result(KIND_CLOSE, 8'h00);
      closed = 1'b1;
    end
    clear_parser();
  endfunction

  // header complete: buffer size check, then payload or an immediate frame end
  function automatic void header_end();
    if (16'(hdr_len) > buf_size || frame_len > 64'(buf_size - 16'(hdr_len))) begin
      add_result(KIND_OVERFLOW, 8'h00);
      closed = 1'b1;
      clear_parser();
    end else if (frame_len == 0) begin
      frame_end();
    end else begin
      bytes_left = frame_len[15:0];
      phase      = PH_PAYLOAD;
    end
  endfunction

  function automatic void length_end();
    if (mask_bit) begin
      hdr_left = MASK_KEY;
      hdr_len  = hdr_len + MASK_KEY;
      phase    = PH_MASK;
    end else begin
      header_end();
    end
  endfunction

  // line assembly: flush on cr or lf, drop a line that runs too long
  function automatic void line_byte(logic [7:0] c);
    if (c == CHR_LF || c == CHR_CR) begin
      for (int unsigned i = 0; i < line_fill; i++) add_result(KIND_CHAR, line_mem[i]);
      line_fill = 0;
    end else if (line_fill < LINE_MAX - 1) begin
      line_mem[line_fill] = c;
      line_fill++;
    end else begin
      line_fill = 0;
    end
  endfunction

  function automatic void predict_word(logic cmd, logic [7:0] b);
    result_t r;
    caused_q.delete();
    if (cmd) begin
      clear_parser();
      closed = 1'b0;
    end else if (!closed) begin
      case (phase)
        PH_FIRST: begin
          opcode  = b[3:0];
          hdr_len = HDR_BASE;
          phase   = PH_SECOND;
        end
        PH_SECOND: begin
          mask_bit  = b[7];
          frame_len = '0;
          if (b[6:0] == LEN_EXT16) begin
            hdr_left = EXT16_BYTES;
            hdr_len  = HDR_EXT16;
            phase    = PH_EXTLEN;
          end else if (b[6:0] == LEN_EXT64) begin
            hdr_left = EXT64_BYTES;
            hdr_len  = HDR_EXT64;
            phase    = PH_EXTLEN;
          end else begin
            frame_len = 64'(b[6:0]);
            length_end();
          end
        end
        PH_EXTLEN: begin
          frame_len = {frame_len[55:0], b};
          if (hdr_left != 0) hdr_left--;
          if (hdr_left == 0) length_end();
        end
        PH_MASK: begin
          if (hdr_left != 0) hdr_left--;
          if (hdr_left == 0) header_end();
        end
        PH_PAYLOAD: begin
          if (opcode == OPC_TEXT) line_byte(b);
          else if (opcode == OPC_PING) add_result(KIND_PING_BYTE, b);
          if (bytes_left != 0) bytes_left--;
          if (bytes_left == 0) frame_end();
        end
        default: clear_parser();
      endcase
    end
    // mark the final result of this word
    if (caused_q.size() > 0) begin
      r = caused_q.pop_back();
      r.last = 1'b1;
      caused_q.push_back(r);
    end
    foreach (caused_q[i]) expected_q.push_back(caused_q[i]);
  endfunction

  // watch both channels and the register port at every edge
  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    if (!rst_ni) begin
      buf_size  = BUF_SIZE_RESET;
      clear_parser();
      closed    = 1'b0;
      line_fill = 0;
      expected_q.delete();
      errors_o  = 0;
    end else begin
      // results first: none of them comes from a word accepted at this edge
      if (res_i.valid && res_i.ready) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, got kind %0d data %02h last %b",
                   $time, res_i.kind, res_i.data, res_i.last);
          errors_o++;
        end else begin
          want = expected_q.pop_front();
          if (res_i.kind !== want.kind || res_i.data !== want.data ||
              res_i.last !== want.last) begin
            $display("%0t: result mismatch, expected kind %0d data %02h last %b, %s %0d %02h %b",
                     $time, want.kind, want.data, want.last, "got kind data last",
                     res_i.kind, res_i.data, res_i.last);
            errors_o++;
          end
        end
      end
      if (cfg_we_i) buf_size = cfg_wdata_i;
      if (rx_i.valid && rx_i.ready) predict_word(rx_i.cmd, rx_i.rx_byte);
    end
    pending_o = expected_q.size();
  end

endmodule

@@ tb/sv/websocket_deframer_line_splitter_top_test.sv @@
// stimulus and verdict for the websocket deframer and text line splitter
module websocket_deframer_line_splitter_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import wsls_pkg::*;

  localparam logic        CMD_BYTE      = 1'b0;
  localparam logic        CMD_START     = 1'b1;
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned HOLD_CYCLES   = 80;
  localparam int unsigned CYCLE_LIMIT   = 500000;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             cfg_we;
  logic [CFG_W-1:0] cfg_wdata;
  int unsigned      check_errors;
  int unsigned      pending;
  int unsigned      cycles = 0;
  int unsigned      words_sent = 0;
  bit               idle_on;
  bit               hold_req;
  logic [CFG_W-1:0] buf_size_now;

  wsls_in_if  rx_if ();
  wsls_out_if res_if ();

  websocket_deframer_line_splitter_top dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .rx_i        (rx_if),
    .res_o       (res_if)
  );

  websocket_deframer_line_splitter_checker checker_inst (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .rx_i        (rx_if),
    .res_i       (res_if),
    .errors_o    (check_errors),
    .pending_o   (pending)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // one word on the receive channel, after a random gap while idle_on is set
  task automatic send_word(input logic cmd, input logic [7:0] b, input bit counted = 1'b1);
    int unsigned gap;
    gap = idle_on ? $urandom_range(0, 3) : 0;
    if (gap != 0) begin
      rx_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    rx_if.valid   <= 1'b1;
    rx_if.cmd     <= cmd;
    rx_if.rx_byte <= b;
    do @(posedge clk); while (!rx_if.ready);
    if (counted) words_sent++;
  endtask

  // stop sending and wait for every expected result
  task automatic drain();
    rx_if.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_buffer_size(input logic [CFG_W-1:0] v);
    drain();
    cfg_we       <= 1'b1;
    cfg_wdata    <= v;
    buf_size_now  = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // whole frame; ended tells whether the session is now closed
  task automatic send_frame(input logic [3:0] opc, input logic masked, input logic [63:0] plen,
                            input int unsigned ext_bytes, input bit long_line,
                            output bit ended);
    int unsigned hdr;
    logic [7:0]  b;
    hdr = 2 + ext_bytes + (masked ? 4 : 0);
    send_word(CMD_BYTE, {4'($urandom_range(0, 15)), opc});
    if (ext_bytes == 2) send_word(CMD_BYTE, {masked, LEN_EXT16});
    else if (ext_bytes == 8) send_word(CMD_BYTE, {masked, LEN_EXT64});
    else send_word(CMD_BYTE, {masked, plen[6:0]});
    for (int i = int'(ext_bytes) - 1; i >= 0; i--) send_word(CMD_BYTE, plen[8*i +: 8]);
    if (masked) repeat (4) send_word(CMD_BYTE, 8'($urandom));
    ended = plen > 64'(buf_size_now) - 64'(hdr);
    if (!ended) begin
      for (int unsigned n = 0; n < plen; n++) begin
        b = 8'($urandom);
        // text: frequent line ends, or one at the very end of a long line
        if (opc == OPC_TEXT) begin
          if (long_line ? (n + 1 == plen) : ($urandom_range(0, 5) == 0))
            b = $urandom_range(0, 1) ? CHR_LF : CHR_CR;
          else
            while (b == CHR_LF || b == CHR_CR) b = 8'($urandom);
        end
        send_word(CMD_BYTE, b);
      end
      ended = (opc == OPC_CLOSE);
    end
  endtask

  task automatic random_frame();
    logic [3:0]  opc;
    logic        masked;
    logic [63:0] plen;
    int unsigned pick, ext_bytes, hdr, base;
    bit          long_line, ended;
    pick = $urandom_range(0, 99);
    if (pick < 45) opc = OPC_TEXT;
    else if (pick < 70) opc = OPC_PING;
    else if (pick < 76) opc = OPC_CLOSE;
    else opc = 4'($urandom_range(0, 15));
    masked    = 1'($urandom_range(0, 1));
    long_line = (opc == OPC_TEXT) && ($urandom_range(0, 11) == 0);
    plen      = long_line ? 64'($urandom_range(64, 70)) : 64'($urandom_range(0, 12));
    pick      = $urandom_range(0, 9);
    ext_bytes = (pick < 6) ? 0 : (pick < 8) ? 2 : 8;
    hdr       = 2 + ext_bytes + (masked ? 4 : 0);
    // now and then a length past the buffer, from just over the edge to huge
    if (ext_bytes != 0 && $urandom_range(0, 2) == 0) begin
      if (ext_bytes == 2) begin
        base = buf_size_now - hdr + 1;
        plen = 64'(base + $urandom_range(0, 65535 - base));
      end else begin
        plen = {$urandom, $urandom} | (64'd1 << $urandom_range(16, 63));
      end
    end
    send_frame(opc, masked, plen, ext_bytes, long_line, ended);
    // bytes of a closed session are ignored, then reopen
    if (ended) begin
      repeat ($urandom_range(0, 2)) send_word(CMD_BYTE, 8'($urandom), 1'b0);
      send_word(CMD_START, 8'($urandom));
    end
  endtask

  task automatic random_traffic(input int unsigned target);
    int unsigned stop_at, pick;
    stop_at = words_sent + target;
    while (words_sent < stop_at) begin
      if ($urandom_range(0, 15) == 0) idle_on = !idle_on;
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        // stray bytes break the framing until a session start
        repeat ($urandom_range(1, 4)) send_word(CMD_BYTE, 8'($urandom));
        send_word(CMD_START, 8'($urandom));
      end else if (pick < 11) begin
        send_word(CMD_START, 8'($urandom));
      end else begin
        random_frame();
      end
    end
  endtask

  // result side: random stalls, and a long hold-off on request
  initial begin : result_sink
    int unsigned stall;
    res_if.ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (hold_req) begin
        res_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        stall = idle_on ? $urandom_range(0, 3) : 0;
        if (stall != 0) begin
          res_if.ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      res_if.ready <= 1'b1;
      do @(posedge clk); while (!res_if.valid);
    end
  end

  initial begin : stimulus
    bit ended;
    rst_n          = 1'b0;
    cfg_we        <= 1'b0;
    cfg_wdata     <= '0;
    rx_if.valid   <= 1'b0;
    rx_if.cmd     <= CMD_BYTE;
    rx_if.rx_byte <= '0;
    buf_size_now   = BUF_SIZE_RESET;
    idle_on        = 1'b1;
    hold_req       = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset buffer size; text line ended by cr, then lf on an empty line
    send_word(CMD_START, 8'hFF);
    send_word(CMD_BYTE, {4'h8, OPC_TEXT});
    send_word(CMD_BYTE, 8'h03);
    send_word(CMD_BYTE, 8'h41);
    send_word(CMD_BYTE, CHR_CR);
    send_word(CMD_BYTE, CHR_LF);
    // masked ping with a 16-bit length
    send_word(CMD_BYTE, {4'h8, OPC_PING});
    send_word(CMD_BYTE, {1'b1, LEN_EXT16});
    send_word(CMD_BYTE, 8'h00);
    send_word(CMD_BYTE, 8'h01);
    send_word(CMD_BYTE, 8'h00);
    send_word(CMD_BYTE, 8'hFF);
    send_word(CMD_BYTE, 8'h5A);
    send_word(CMD_BYTE, 8'hA5);
    send_word(CMD_BYTE, 8'hFF);
    // empty ping completes on its last header byte
    send_word(CMD_BYTE, {4'h8, OPC_PING});
    send_word(CMD_BYTE, 8'h00);
    // close, an ignored byte, then a new session
    send_word(CMD_BYTE, {4'h8, OPC_CLOSE});
    send_word(CMD_BYTE, 8'h00);
    send_word(CMD_BYTE, 8'h80, 1'b0);
    send_word(CMD_START, 8'h00);

    // long receiver hold-off while a 39-char line is flushed
    random_traffic(15);
    hold_req = 1'b1;
    send_frame(OPC_PING, 1'b0, 64'd1, 0, 1'b0, ended);
    send_frame(OPC_TEXT, 1'b1, 64'd40, 0, 1'b1, ended);
    random_traffic(15);

    // smallest buffer: exact fit, one byte over, masked fit
    set_buffer_size(16);
    idle_on = 1'b0;
    send_frame(OPC_TEXT, 1'b0, 64'd14, 0, 1'b0, ended);
    send_frame(OPC_TEXT, 1'b0, 64'd15, 0, 1'b0, ended);
    send_word(CMD_START, 8'h00);
    send_frame(OPC_PING, 1'b1, 64'd10, 0, 1'b0, ended);
    random_traffic(20);

    // largest buffer, largest 64-bit length
    set_buffer_size(16'hFFFF);
    idle_on = 1'b1;
    send_frame(OPC_PING, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 8, 1'b0, ended);
    send_word(CMD_START, 8'hFF);
    random_traffic(20);

    set_buffer_size(16'($urandom_range(16, 300)));
    random_traffic(20);

    drain();
    if (check_errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule
